FILE: sv/vdma_pkg.sv
// vdma_pkg: shared types and constants for the vram dma block controller
// holds the action codes, transaction structs and register reset values
// no dependencies
package vdma_pkg;

   // default width of the video memory offset
   localparam int VRAM_ADDR_BITS_DEFAULT = 13;

   localparam int TARGET_W = 13;
   localparam int SOURCE_W = 16;
   localparam int BYTES_W  = 12;

   localparam logic [7:0] REG_RESET_VAL = 8'hFF;
   localparam logic [7:0] ALIGN_MASK    = 8'hF0;
   localparam logic [7:0] BLOCK_MASK    = 8'h7F;
   localparam logic [7:0] BLANK_STALL   = 8'd8;
   localparam logic [BYTES_W-1:0] BLOCK_BYTES = 12'h010;

   typedef enum logic [2:0] {
      ACT_SRC_HI = 3'd0,
      ACT_SRC_LO = 3'd1,
      ACT_TGT_HI = 3'd2,
      ACT_TGT_LO = 3'd3,
      ACT_START  = 3'd4,
      ACT_READ   = 3'd5,
      ACT_TICK   = 3'd6
   } action_type;

   typedef struct packed {
      logic [2:0] action;
      logic [7:0] value;
   } req_type;

   typedef struct packed {
      logic                xfer_valid;
      logic [SOURCE_W-1:0] xfer_source;
      logic [TARGET_W-1:0] xfer_target;
      logic [BYTES_W-1:0]  xfer_bytes;
      logic [7:0]          read_data;
      logic [7:0]          stall_cycles;
   } rsp_type;

endpackage

FILE: sv/vram_dma_block_controller_top.sv
// vram_dma_block_controller_top: register file and descriptor issue for
// general and blanking vram copies; depends on vdma_pkg
//
// channel   ports                           direction  contents
// req       req_valid req_ready req_data    in         action code and write byte
// rsp       rsp_valid rsp_ready rsp_data    out        copy descriptor, read byte, stall
//
// one transaction per cycle sustained while rsp_ready is high; every req transaction
// yields exactly one rsp transaction, registered, in the cycle after acceptance
// the whole decode and register update sits between the req port and the
// single rsp output register
// req_ready drops only while a result sits in the output register and
// rsp_ready is low
// synchronous active-high reset restores the address and status bytes to
// 0xff and leaves no transfer armed
module vram_dma_block_controller_top #(
   parameter int VRAM_ADDR_BITS = vdma_pkg::VRAM_ADDR_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  vdma_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output vdma_pkg::rsp_type rsp_data
);

   localparam int BW = vdma_pkg::BYTES_W;

   // programmed address bytes and status
   logic [7:0] src_hi_ff, src_hi_in;
   logic [7:0] src_lo_ff, src_lo_in;
   logic [7:0] tgt_hi_ff, tgt_hi_in;
   logic [7:0] tgt_lo_ff, tgt_lo_in;
   logic [7:0] status_ff, status_in;

   // running blanking transfer
   logic [vdma_pkg::SOURCE_W-1:0] act_src_ff, act_src_in;
   logic [VRAM_ADDR_BITS-1:0]     act_tgt_ff, act_tgt_in;
   logic [BW-1:0]                 remain_ff, remain_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   vdma_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic                          accept;
   logic [vdma_pkg::SOURCE_W-1:0] src_addr;
   logic [15:0]                   tgt_full;
   logic [VRAM_ADDR_BITS-1:0]     tgt_addr;
   logic [7:0]                    blocks;
   logic [BW-1:0]                 remain_next_tick;

   // output stage frees up when empty or being drained
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // low nibble of the low address bytes is ignored
   assign src_addr = {src_hi_ff, src_lo_ff & vdma_pkg::ALIGN_MASK};
   assign tgt_full = {tgt_hi_ff, tgt_lo_ff & vdma_pkg::ALIGN_MASK};
   assign tgt_addr = tgt_full[VRAM_ADDR_BITS-1:0];
   assign blocks   = (req_data.value & vdma_pkg::BLOCK_MASK) + 8'd1;
   assign remain_next_tick = remain_ff - vdma_pkg::BLOCK_BYTES;

   always_comb begin
      src_hi_in  = src_hi_ff;
      src_lo_in  = src_lo_ff;
      tgt_hi_in  = tgt_hi_ff;
      tgt_lo_in  = tgt_lo_ff;
      status_in  = status_ff;
      act_src_in = act_src_ff;
      act_tgt_in = act_tgt_ff;
      remain_in  = remain_ff;
      rsp_data_in = '0;

      unique case (req_data.action)
         vdma_pkg::ACT_SRC_HI: begin
            src_hi_in = req_data.value;
         end
         vdma_pkg::ACT_SRC_LO: begin
            src_lo_in = req_data.value;
         end
         vdma_pkg::ACT_TGT_HI: begin
            tgt_hi_in = req_data.value;
         end
         vdma_pkg::ACT_TGT_LO: begin
            tgt_lo_in = req_data.value;
         end
         vdma_pkg::ACT_START: begin
            if (!req_data.value[7]) begin
               if (remain_ff != '0) begin
                  // cancel the armed blanking transfer
                  remain_in = '0;
                  status_in = vdma_pkg::REG_RESET_VAL;
               end else begin
                  // general transfer, all in one descriptor
                  rsp_data_in.xfer_valid   = 1'b1;
                  rsp_data_in.xfer_source  = src_addr;
                  rsp_data_in.xfer_target  = vdma_pkg::TARGET_W'(tgt_addr);
                  rsp_data_in.xfer_bytes   = {blocks, 4'b0000};
                  rsp_data_in.stall_cycles = blocks;
                  src_hi_in = vdma_pkg::REG_RESET_VAL;
                  src_lo_in = vdma_pkg::REG_RESET_VAL;
                  tgt_hi_in = vdma_pkg::REG_RESET_VAL;
                  tgt_lo_in = vdma_pkg::REG_RESET_VAL;
                  status_in = vdma_pkg::REG_RESET_VAL;
               end
            end else begin
               // arm (or re-arm) a blanking transfer
               act_src_in = src_addr;
               act_tgt_in = tgt_addr;
               remain_in  = {blocks, 4'b0000};
               status_in  = req_data.value & vdma_pkg::BLOCK_MASK;
            end
         end
         vdma_pkg::ACT_READ: begin
            rsp_data_in.read_data = status_ff;
         end
         vdma_pkg::ACT_TICK: begin
            if (remain_ff != '0) begin
               rsp_data_in.xfer_valid   = 1'b1;
               rsp_data_in.xfer_source  = act_src_ff;
               rsp_data_in.xfer_target  = vdma_pkg::TARGET_W'(act_tgt_ff);
               rsp_data_in.xfer_bytes   = vdma_pkg::BLOCK_BYTES;
               rsp_data_in.stall_cycles = vdma_pkg::BLANK_STALL;
               remain_in  = remain_next_tick;
               act_src_in = act_src_ff + vdma_pkg::SOURCE_W'(vdma_pkg::BLOCK_BYTES);
               act_tgt_in = act_tgt_ff + VRAM_ADDR_BITS'(vdma_pkg::BLOCK_BYTES);
               status_in  = status_ff - 8'd1;
               // last block closes the transfer
               if (remain_next_tick == '0) begin
                  src_hi_in = vdma_pkg::REG_RESET_VAL;
                  src_lo_in = vdma_pkg::REG_RESET_VAL;
                  tgt_hi_in = vdma_pkg::REG_RESET_VAL;
                  tgt_lo_in = vdma_pkg::REG_RESET_VAL;
                  status_in = vdma_pkg::REG_RESET_VAL;
               end
            end
         end
         default: begin
            // unused action code: no state change, all-zero result
         end
      endcase
   end

   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_hi_ff    <= vdma_pkg::REG_RESET_VAL;
         src_lo_ff    <= vdma_pkg::REG_RESET_VAL;
         tgt_hi_ff    <= vdma_pkg::REG_RESET_VAL;
         tgt_lo_ff    <= vdma_pkg::REG_RESET_VAL;
         status_ff    <= vdma_pkg::REG_RESET_VAL;
         act_src_ff   <= '0;
         act_tgt_ff   <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            src_hi_ff  <= src_hi_in;
            src_lo_ff  <= src_lo_in;
            tgt_hi_ff  <= tgt_hi_in;
            tgt_lo_ff  <= tgt_lo_in;
            status_ff  <= status_in;
            act_src_ff <= act_src_in;
            act_tgt_ff <= act_tgt_in;
            remain_ff  <= remain_in;
         end
      end
   end

   // payload register, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // remaining length only ever moves in whole blocks
   a_remain_aligned: assert property (@(posedge clock) disable iff (reset)
      remain_ff[3:0] == 4'd0)
      else $error("remaining length not block aligned");

   // a result without a descriptor carries no length or stall
   a_idle_result_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.xfer_valid |->
         rsp_data_ff.xfer_bytes == '0 && rsp_data_ff.stall_cycles == 8'd0)
      else $error("non-descriptor result has length or stall");

   // a status read returns the status held when it was accepted
   a_read_status: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.action == vdma_pkg::ACT_READ |=>
         rsp_data_ff.read_data == $past(status_ff))
      else $error("status read returned wrong byte");

   // the last blanking block ends the transfer and restores status
   a_last_block: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.action == vdma_pkg::ACT_TICK && remain_ff == BW'(16) |=>
         remain_ff == '0 && status_ff == vdma_pkg::REG_RESET_VAL)
      else $error("last blanking block did not close the transfer");

endmodule

FILE: verif/vdma_descriptor_checker.sv
// vdma_descriptor_checker: watches the req and rsp channels of the vram dma block
// controller, predicts every rsp transaction and compares it field by field
// depends on vdma_pkg for the transaction structs, action codes and constants
module vdma_descriptor_checker #(
   parameter int VRAM_ADDR_BITS = vdma_pkg::VRAM_ADDR_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  vdma_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  vdma_pkg::rsp_type rsp_data,
   output int                mismatches,
   output int                pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [15:0] TARGET_MASK  = 16'((32'd1 << VRAM_ADDR_BITS) - 32'd1);
   localparam int          REPORT_LIMIT = 10;

   // shadow copy of the register file and the armed blank transfer
   logic [7:0]                    src_hi, src_lo, tgt_hi, tgt_lo, status;
   logic [vdma_pkg::SOURCE_W-1:0] blank_src;
   logic [vdma_pkg::TARGET_W-1:0] blank_tgt;
   logic [vdma_pkg::BYTES_W-1:0]  blank_left;

   vdma_pkg::rsp_type expected_rsp_q[$];
   vdma_pkg::rsp_type want;

   initial begin
      mismatches = 0;
      pending    = 0;
   end

   function automatic void restore_addr_status();
      src_hi = vdma_pkg::REG_RESET_VAL;
      src_lo = vdma_pkg::REG_RESET_VAL;
      tgt_hi = vdma_pkg::REG_RESET_VAL;
      tgt_lo = vdma_pkg::REG_RESET_VAL;
      status = vdma_pkg::REG_RESET_VAL;
   endfunction

   function automatic vdma_pkg::rsp_type issue_descriptor(input vdma_pkg::req_type r);
      vdma_pkg::rsp_type            res;
      logic [15:0]                  s;
      logic [15:0]                  d;
      logic [vdma_pkg::BYTES_W-1:0] blocks;
      res    = '0;
      s      = {src_hi, src_lo & vdma_pkg::ALIGN_MASK};
      d      = {tgt_hi, tgt_lo & vdma_pkg::ALIGN_MASK} & TARGET_MASK;
      blocks = vdma_pkg::BYTES_W'(r.value & vdma_pkg::BLOCK_MASK) + vdma_pkg::BYTES_W'(1);
      case (r.action)
         vdma_pkg::ACT_SRC_HI: src_hi = r.value;
         vdma_pkg::ACT_SRC_LO: src_lo = r.value;
         vdma_pkg::ACT_TGT_HI: tgt_hi = r.value;
         vdma_pkg::ACT_TGT_LO: tgt_lo = r.value;
         vdma_pkg::ACT_START: begin
            if (!r.value[7]) begin
               if (blank_left != '0) begin
                  // cancel of an armed blank transfer
                  blank_left = '0;
                  status     = vdma_pkg::REG_RESET_VAL;
               end else begin
                  res.xfer_valid   = 1'b1;
                  res.xfer_source  = s;
                  res.xfer_target  = d[vdma_pkg::TARGET_W-1:0];
                  res.xfer_bytes   = blocks << 4;
                  res.stall_cycles = blocks[7:0];
                  restore_addr_status();
               end
            end else begin
               blank_src  = s;
               blank_tgt  = d[vdma_pkg::TARGET_W-1:0];
               blank_left = blocks << 4;
               status     = r.value & vdma_pkg::BLOCK_MASK;
            end
         end
         vdma_pkg::ACT_READ: res.read_data = status;
         vdma_pkg::ACT_TICK: begin
            if (blank_left != '0) begin
               res.xfer_valid   = 1'b1;
               res.xfer_source  = blank_src;
               res.xfer_target  = blank_tgt;
               res.xfer_bytes   = vdma_pkg::BLOCK_BYTES;
               res.stall_cycles = vdma_pkg::BLANK_STALL;
               blank_left = (blank_left >= vdma_pkg::BLOCK_BYTES) ?
                            blank_left - vdma_pkg::BLOCK_BYTES : '0;
               blank_src  = blank_src + vdma_pkg::SOURCE_W'(vdma_pkg::BLOCK_BYTES);
               blank_tgt  = vdma_pkg::TARGET_W'((16'(blank_tgt) +
                            16'(vdma_pkg::BLOCK_BYTES)) & TARGET_MASK);
               status     = status - 8'd1;
               if (blank_left == '0) restore_addr_status();
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   task automatic log_mismatch(input string what, input vdma_pkg::rsp_type exp_r,
                               input vdma_pkg::rsp_type got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
         $display("%0t rsp %s: expected valid=%0d src=%h tgt=%h bytes=%0d rd=%h stall=%0d",
                  $realtime, what, exp_r.xfer_valid, exp_r.xfer_source, exp_r.xfer_target,
                  exp_r.xfer_bytes, exp_r.read_data, exp_r.stall_cycles);
         $display("%0t   actual valid=%0d src=%h tgt=%h bytes=%0d rd=%h stall=%0d",
                  $realtime, got.xfer_valid, got.xfer_source, got.xfer_target,
                  got.xfer_bytes, got.read_data, got.stall_cycles);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         restore_addr_status();
         blank_src  = '0;
         blank_tgt  = '0;
         blank_left = '0;
         expected_rsp_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp_q.size() == 0) begin
               log_mismatch("with nothing expected", '0, rsp_data);
            end else begin
               want = expected_rsp_q.pop_front();
               if (want.xfer_valid !== rsp_data.xfer_valid ||
                   want.xfer_source !== rsp_data.xfer_source ||
                   want.xfer_target !== rsp_data.xfer_target ||
                   want.xfer_bytes !== rsp_data.xfer_bytes ||
                   want.read_data !== rsp_data.read_data ||
                   want.stall_cycles !== rsp_data.stall_cycles) begin
                  log_mismatch("mismatch", want, rsp_data);
               end
            end
         end
         if (req_valid && req_ready) expected_rsp_q.push_back(issue_descriptor(req_data));
      end
      pending = expected_rsp_q.size();
   end

endmodule

FILE: verif/testbench.sv
// testbench: stimulus and verdict for vram_dma_block_controller_top
// depends on vdma_pkg, the block itself and vdma_descriptor_checker
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // action code that the block leaves unused
   localparam logic [2:0] ACT_UNUSED  = 3'd7;
   localparam int         DRAIN_LIMIT = 5000;
   localparam int         HOLD_CYCLES = 300;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   vdma_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   vdma_pkg::rsp_type rsp_data;

   int   mismatches;
   int   pending;
   int   items_sent    = 0;
   int   drain_cycles  = 0;
   // idle chance per cycle in percent, sender side and receiver side
   int   send_idle_pct = 7;
   int   rcv_idle_pct  = 69;
   // long receiver hold-off, raised by its own process
   logic hold_rsp      = 1'b0;

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   vram_dma_block_controller_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   vdma_descriptor_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .mismatches (mismatches),
      .pending    (pending)
   );

   // receiver: random stalls, forced low during a hold-off
   always @(posedge clock) begin
      if (hold_rsp) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
   end

   // hold the rsp side off, then release it
   task automatic hold_off_rsp(input int cycles);
      hold_rsp <= 1'b1;
      repeat (cycles) @(posedge clock);
      hold_rsp <= 1'b0;
   endtask

   // offer one req transaction and return at the edge that accepts it;
   // valid stays high on return so the caller drives the next step at once
   task automatic send_item(input logic [2:0] act, input logic [7:0] val);
      logic ready_seen;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_data   <= '{action: act, value: val};
      ready_seen = 1'b0;
      // ready is sampled mid-cycle, away from the edge where everything moves
      while (!ready_seen) begin
         @(negedge clock);
         ready_seen = req_ready;
         @(posedge clock);
      end
      if (act != ACT_UNUSED) items_sent++;
   endtask

   task automatic write_addresses(input logic [7:0] sh, input logic [7:0] sl,
                                  input logic [7:0] th, input logic [7:0] tl);
      send_item(vdma_pkg::ACT_SRC_HI, sh);
      send_item(vdma_pkg::ACT_SRC_LO, sl);
      send_item(vdma_pkg::ACT_TGT_HI, th);
      send_item(vdma_pkg::ACT_TGT_LO, tl);
   endtask

   // mostly well-formed programming sequences, the rest raw noise
   task automatic random_phase(input int count);
      int stop_at;
      int blocks;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         if ($urandom_range(99) < 70) begin
            write_addresses(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            if ($urandom_range(1) == 1) begin
               // blank transfer: short lengths mostly, now and then a long one
               blocks = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(7);
               send_item(vdma_pkg::ACT_START, 8'h80 | 8'(blocks));
               // one tick past the end to see the idle tick
               for (int i = 0; i <= blocks + 1; i++) begin
                  case ($urandom_range(19))
                     // cancel or re-arm in the middle of the transfer
                     0: send_item(vdma_pkg::ACT_START, 8'($urandom));
                     1: send_item(vdma_pkg::ACT_READ, 8'($urandom));
                     // address byte poked while armed
                     2: send_item(3'($urandom_range(3)), 8'($urandom));
                     default: send_item(vdma_pkg::ACT_TICK, 8'($urandom));
                  endcase
               end
               send_item(vdma_pkg::ACT_READ, 8'($urandom));
            end else begin
               send_item(vdma_pkg::ACT_START, 8'($urandom_range(127)));
               send_item(vdma_pkg::ACT_READ, 8'($urandom));
            end
         end else begin
            send_item(3'($urandom_range(7)), 8'($urandom));
         end
      end
   endtask

   // run limit, far beyond the slowest correct run
   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // ---- directed part ----
      // reset status, idle tick, unused action
      send_item(vdma_pkg::ACT_READ, 8'h00);
      send_item(vdma_pkg::ACT_TICK, 8'h00);
      send_item(ACT_UNUSED, 8'hA5);
      // general transfer straight from the reset address bytes, one block
      send_item(vdma_pkg::ACT_START, 8'h00);
      // unaligned low bytes, largest general transfer
      write_addresses(8'h12, 8'h3F, 8'h9A, 8'hC7);
      send_item(vdma_pkg::ACT_START, 8'h7F);
      send_item(vdma_pkg::ACT_READ, 8'h00);
      // top of the source address space, blank transfer of two blocks wraps the source
      write_addresses(8'hFF, 8'hF5, 8'hFF, 8'h0F);
      send_item(vdma_pkg::ACT_START, 8'h81);
      send_item(vdma_pkg::ACT_READ, 8'h00);
      send_item(vdma_pkg::ACT_TICK, 8'h00);
      send_item(vdma_pkg::ACT_TICK, 8'hFF);
      send_item(vdma_pkg::ACT_READ, 8'h00);
      // arm then cancel, following tick does nothing
      send_item(vdma_pkg::ACT_START, 8'h85);
      send_item(vdma_pkg::ACT_START, 8'h05);
      send_item(vdma_pkg::ACT_READ, 8'h00);
      send_item(vdma_pkg::ACT_TICK, 8'h00);
      // re-arm while armed, then finish the single remaining block
      send_item(vdma_pkg::ACT_START, 8'h83);
      send_item(vdma_pkg::ACT_TICK, 8'h00);
      write_addresses(8'h00, 8'h00, 8'h00, 8'h00);
      send_item(vdma_pkg::ACT_START, 8'h80);
      send_item(vdma_pkg::ACT_TICK, 8'h00);
      send_item(vdma_pkg::ACT_READ, 8'h00);
      // largest blank length armed and cancelled
      send_item(vdma_pkg::ACT_START, 8'hFF);
      send_item(vdma_pkg::ACT_START, 8'h7F);

      // ---- random part, first phase: light sender idling, heavy receiver stalls ----
      random_phase(630);

      // second phase: roles swapped
      send_idle_pct = 69;
      rcv_idle_pct <= 7;
      random_phase(630);

      // third phase: no idling on either side
      send_idle_pct = 0;
      rcv_idle_pct <= 0;

      // long rsp hold-off while the sender keeps offering, so req backs up
      fork
         hold_off_rsp(HOLD_CYCLES);
      join_none
      repeat (40) send_item(3'($urandom_range(6)), 8'($urandom));

      // sender pauses until every expected transaction has come back
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      @(posedge clock);

      random_phase(600);
      req_valid <= 1'b0;

      // ---- drain and verdict ----
      do begin
         @(negedge clock);
         drain_cycles++;
      end while (pending != 0 && drain_cycles < DRAIN_LIMIT);
      if (pending != 0) begin
         $display("Test completed with failures");
      end else begin
         // wait on to catch any stray rsp transaction
         repeat (8) @(posedge clock);
         if (mismatches == 0 && pending == 0) begin
            $display("Test completed successfully");
         end else begin
            $display("Test completed with failures");
         end
      end
      $finish;
   end

endmodule

FILE: sim.f
sv/vdma_pkg.sv
sv/vram_dma_block_controller_top.sv
verif/vdma_descriptor_checker.sv
verif/testbench.sv
